@@ design/nsp_pkg.sv @@
`timescale 1ns / 1ps
package nsp_pkg;

  typedef enum logic [12:0] {
    PH_IDLE    = 13'b0000000000001,
    PH_LEN1    = 13'b0000000000010,
    PH_LEN2    = 13'b0000000000100,
    PH_HDR     = 13'b0000000001000,
    PH_NETDESC = 13'b0000000010000,
    PH_TSL1    = 13'b0000000100000,
    PH_TSL2    = 13'b0000001000000,
    PH_ENTRY   = 13'b0000010000000,
    PH_DTAG    = 13'b0000100000000,
    PH_DLEN    = 13'b0001000000000,
    PH_DBODY   = 13'b0010000000000,
    PH_CRC     = 13'b0100000000000,
    PH_SKIP    = 13'b1000000000000
  } phase_t;

  localparam logic [1:0] KIND_TS     = 2'd0;
  localparam logic [1:0] KIND_OK     = 2'd1;
  localparam logic [1:0] KIND_CRC    = 2'd2;
  localparam logic [1:0] KIND_STRUCT = 2'd3;

  localparam logic [7:0]  TAG_SAT   = 8'h43;
  localparam logic [7:0]  TAG_TERR  = 8'h5A;
  localparam logic [31:0] CRC_POLY  = 32'h04C11DB7;
  localparam logic [26:0] CAP_FREQ  = 27'd99999999;
  localparam logic [26:0] CAP_ORBIT = 27'd9999;
  localparam logic [26:0] CAP_SR    = 27'd9999999;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] ident;
    logic [15:0] original_net;
    logic        sat_present;
    logic [26:0] sat_frequency;
    logic [13:0] sat_orbit;
    logic [7:0]  sat_mode_bits;
    logic [23:0] sat_symbol_rate;
    logic [3:0]  sat_fec;
    logic        terr_present;
    logic [31:0] terr_frequency;
    logic [21:0] terr_params;
  } res_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    r = c ^ {b, 24'h0};
    for (int i = 0; i < 8; i++) begin
      r = r[31] ? ((r << 1) ^ CRC_POLY) : (r << 1);
    end
    return r;
  endfunction

  function automatic logic [7:0] bcd_pair(input logic [7:0] b);
    return ({4'h0, b[7:4]} * 8'd10) + {4'h0, b[3:0]};
  endfunction

  // acc*scale + digit, clamped at cap
  function automatic logic [26:0] bcd_step(input logic [26:0] acc, input logic [7:0] digit,
                                           input logic [6:0] scale, input logic [26:0] cap);
    logic [34:0] v;
    v = {8'h0, acc} * {28'h0, scale} + {27'h0, digit};
    return (v > {8'h0, cap}) ? cap : v[26:0];
  endfunction

endpackage

@@ design/nsp_front.sv @@
`timescale 1ns / 1ps
module nsp_front #(
  parameter int MAX_SECTION_BYTES = 1024
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          take,
  input  logic [7:0]    data_byte,
  input  logic          section_start,
  output logic          push,
  output nsp_pkg::res_t push_res
);
  import nsp_pkg::*;

  localparam logic [12:0] MAX_B = 13'(MAX_SECTION_BYTES);

  phase_t      ph_r, ph_nxt;
  logic [11:0] sbl_r, sbl_nxt, tsl_r, tsl_nxt, edl_r, edl_nxt;
  logic [7:0]  tag_r, tag_nxt, dbl_r, dbl_nxt, dbi_r, dbi_nxt;
  logic [31:0] crc_r, crc_nxt;
  logic [37:0] hdr_r, hdr_nxt;
  logic        err_r, err_nxt;
  // entry record
  logic [15:0] tsid_r, tsid_nxt, onid_r, onid_nxt;
  logic        satp_r, satp_nxt, terp_r, terp_nxt;
  logic [26:0] freq_r, freq_nxt;
  logic [13:0] orb_r, orb_nxt;
  logic [7:0]  mode_r, mode_nxt;
  logic [23:0] sr_r, sr_nxt;
  logic [3:0]  fec_r, fec_nxt;
  logic [31:0] tf_r, tf_nxt;
  logic [21:0] tp_r, tp_nxt;

  logic        fin, st, ov;
  logic [11:0] v, sbl_d, tsl_d, edl_d;
  logic [26:0] t27;

  always_comb begin
    ph_nxt = ph_r;   sbl_nxt = sbl_r; tsl_nxt = tsl_r; edl_nxt = edl_r;
    tag_nxt = tag_r; dbl_nxt = dbl_r; dbi_nxt = dbi_r; crc_nxt = crc_r;
    hdr_nxt = hdr_r; err_nxt = err_r;
    tsid_nxt = tsid_r; onid_nxt = onid_r; satp_nxt = satp_r; terp_nxt = terp_r;
    freq_nxt = freq_r; orb_nxt = orb_r; mode_nxt = mode_r; sr_nxt = sr_r;
    fec_nxt = fec_r; tf_nxt = tf_r; tp_nxt = tp_r;
    fin = 1'b0; st = 1'b0; ov = 1'b0;
    v = 12'h0; t27 = 27'h0;
    sbl_d = sbl_r - 12'd1;
    tsl_d = tsl_r - 12'd1;
    edl_d = edl_r - 12'd1;
    if (section_start) begin
      // restart drops anything in flight
      sbl_nxt = 12'h0; tsl_nxt = 12'h0; edl_nxt = 12'h0;
      tag_nxt = 8'h0; dbl_nxt = 8'h0; dbi_nxt = 8'h0;
      hdr_nxt = 38'h0; err_nxt = 1'b0;
      tsid_nxt = 16'h0; onid_nxt = 16'h0; satp_nxt = 1'b0; terp_nxt = 1'b0;
      freq_nxt = 27'h0; orb_nxt = 14'h0; mode_nxt = 8'h0; sr_nxt = 24'h0;
      fec_nxt = 4'h0; tf_nxt = 32'h0; tp_nxt = 22'h0;
      crc_nxt = crc_byte(32'hFFFF_FFFF, data_byte);
      ph_nxt = PH_LEN1;
    end else if (ph_r != PH_IDLE) begin
      crc_nxt = crc_byte(crc_r, data_byte);
      v = {4'h0, data_byte};
      case (ph_r)
        PH_LEN1: begin
          sbl_nxt = {data_byte[3:0], 8'h0};
          ph_nxt = PH_LEN2;
        end
        PH_LEN2: begin
          v = {sbl_r[11:8], data_byte};
          if ({1'b0, v} + 13'd3 > MAX_B) begin
            ov = 1'b1;
            ph_nxt = PH_IDLE;
          end else begin
            sbl_nxt = v;
            dbi_nxt = 8'h0;
            ph_nxt = PH_HDR;
            if (v < 12'd13) err_nxt = 1'b1;
            if (v == 12'd0) st = 1'b1;
          end
        end
        default: begin
          sbl_nxt = sbl_d;
          case (ph_r)
            PH_HDR: begin
              case (dbi_r)
                8'd0: hdr_nxt[37:30] = data_byte;
                8'd1: hdr_nxt[29:22] = data_byte;
                8'd2: hdr_nxt[21:16] = data_byte[5:0];
                8'd3: hdr_nxt[15:8] = data_byte;
                8'd4: hdr_nxt[7:0] = data_byte;
                8'd5: tsl_nxt = {data_byte[3:0], 8'h0};
                default: begin
                  v = {tsl_r[11:8], data_byte};
                  if (err_r || ({1'b0, v} + 13'd6 > {1'b0, sbl_d})) begin
                    err_nxt = 1'b1; ph_nxt = PH_SKIP;
                  end else begin
                    tsl_nxt = v;
                    ph_nxt = (v != 12'd0) ? PH_NETDESC : PH_TSL1;
                  end
                end
              endcase
              dbi_nxt = dbi_r + 8'd1;
            end
            PH_NETDESC: begin
              tsl_nxt = tsl_d;
              if (tsl_d == 12'd0) ph_nxt = PH_TSL1;
            end
            PH_TSL1: begin
              tsl_nxt = {data_byte[3:0], 8'h0};
              ph_nxt = PH_TSL2;
            end
            PH_TSL2: begin
              v = {tsl_r[11:8], data_byte};
              if (v == 12'd0 || ({1'b0, v} + 13'd4 != {1'b0, sbl_d})) begin
                err_nxt = 1'b1; ph_nxt = PH_SKIP;
              end else begin
                tsl_nxt = v; dbi_nxt = 8'h0; ph_nxt = PH_ENTRY;
              end
            end
            PH_ENTRY: begin
              if (dbi_r == 8'd0 && tsl_r < 12'd6) begin
                err_nxt = 1'b1; ph_nxt = PH_SKIP;
              end else begin
                if (dbi_r == 8'd0) begin
                  tsid_nxt = 16'h0; onid_nxt = 16'h0; satp_nxt = 1'b0; terp_nxt = 1'b0;
                  freq_nxt = 27'h0; orb_nxt = 14'h0; mode_nxt = 8'h0; sr_nxt = 24'h0;
                  fec_nxt = 4'h0; tf_nxt = 32'h0; tp_nxt = 22'h0;
                end
                tsl_nxt = tsl_d;
                case (dbi_r)
                  8'd0: tsid_nxt[15:8] = data_byte;
                  8'd1: tsid_nxt[7:0] = data_byte;
                  8'd2: onid_nxt[15:8] = data_byte;
                  8'd3: onid_nxt[7:0] = data_byte;
                  8'd4: edl_nxt = {data_byte[3:0], 8'h0};
                  default: begin
                    v = {edl_r[11:8], data_byte};
                    if (v > tsl_d) begin
                      err_nxt = 1'b1; ph_nxt = PH_SKIP;
                    end else begin
                      edl_nxt = v;
                      if (v == 12'd0) fin = 1'b1;
                      else ph_nxt = PH_DTAG;
                    end
                  end
                endcase
                if (ph_nxt == PH_ENTRY && !fin) dbi_nxt = dbi_r + 8'd1;
              end
            end
            PH_DTAG: begin
              if (edl_r < 12'd2) begin
                err_nxt = 1'b1; ph_nxt = PH_SKIP;
              end else begin
                tsl_nxt = tsl_d; edl_nxt = edl_d;
                tag_nxt = data_byte; ph_nxt = PH_DLEN;
              end
            end
            PH_DLEN: begin
              tsl_nxt = tsl_d; edl_nxt = edl_d;
              if ({4'h0, data_byte} > edl_d ||
                  (tag_r == TAG_SAT && data_byte < 8'd11) ||
                  (tag_r == TAG_TERR && data_byte < 8'd7)) begin
                err_nxt = 1'b1; ph_nxt = PH_SKIP;
              end else begin
                if (tag_r == TAG_SAT) begin
                  freq_nxt = 27'h0; orb_nxt = 14'h0; mode_nxt = 8'h0;
                  sr_nxt = 24'h0; fec_nxt = 4'h0; satp_nxt = 1'b1;
                end else if (tag_r == TAG_TERR) begin
                  tf_nxt = 32'h0; tp_nxt = 22'h0; terp_nxt = 1'b1;
                end
                dbl_nxt = data_byte; dbi_nxt = 8'h0;
                if (data_byte != 8'd0) ph_nxt = PH_DBODY;
                else if (edl_d == 12'd0) fin = 1'b1;
                else ph_nxt = PH_DTAG;
              end
            end
            PH_DBODY: begin
              tsl_nxt = tsl_d; edl_nxt = edl_d;
              if (tag_r == TAG_SAT) begin
                if (dbi_r < 8'd4) begin
                  freq_nxt = bcd_step(freq_r, bcd_pair(data_byte), 7'd100, CAP_FREQ);
                end else if (dbi_r < 8'd6) begin
                  t27 = bcd_step({13'h0, orb_r}, bcd_pair(data_byte), 7'd100, CAP_ORBIT);
                  orb_nxt = t27[13:0];
                end else if (dbi_r == 8'd6) begin
                  mode_nxt = data_byte;
                end else if (dbi_r < 8'd10) begin
                  t27 = bcd_step({3'h0, sr_r}, bcd_pair(data_byte), 7'd100, CAP_SR);
                  sr_nxt = t27[23:0];
                end else if (dbi_r == 8'd10) begin
                  t27 = bcd_step({3'h0, sr_r}, {4'h0, data_byte[7:4]}, 7'd10, CAP_SR);
                  sr_nxt = t27[23:0];
                  fec_nxt = data_byte[3:0];
                end
              end else if (tag_r == TAG_TERR) begin
                if (dbi_r < 8'd4) tf_nxt = {tf_r[23:0], data_byte};
                else if (dbi_r == 8'd4) tp_nxt[21:16] = data_byte[7:2];
                else if (dbi_r == 8'd5) tp_nxt[15:8] = data_byte;
                else if (dbi_r == 8'd6) tp_nxt[7:0] = data_byte;
              end
              if (dbi_r != 8'd255) dbi_nxt = dbi_r + 8'd1;
              dbl_nxt = dbl_r - 8'd1;
              if (dbl_r == 8'd1) begin
                if (edl_d == 12'd0) fin = 1'b1;
                else ph_nxt = PH_DTAG;
              end
            end
            default: ;
          endcase
          if (fin) begin
            dbi_nxt = 8'h0;
            ph_nxt = (tsl_nxt != 12'd0) ? PH_ENTRY : PH_CRC;
          end
          if (sbl_d == 12'd0) st = 1'b1;
        end
      endcase
      if (st) ph_nxt = PH_IDLE;
    end
  end

  always_comb begin
    push_res = '0;
    push = fin | st | ov;
    if (ov) begin
      push_res.kind = KIND_STRUCT;
    end else if (st) begin
      push_res.kind = (crc_nxt != 32'h0) ? KIND_CRC : (err_nxt ? KIND_STRUCT : KIND_OK);
      push_res.ident = hdr_nxt[37:22];
      push_res.terr_params = hdr_nxt[21:0];
    end else begin
      push_res.kind = KIND_TS;
      push_res.ident = tsid_nxt;
      push_res.original_net = onid_nxt;
      push_res.sat_present = satp_nxt;
      push_res.sat_frequency = freq_nxt;
      push_res.sat_orbit = orb_nxt;
      push_res.sat_mode_bits = mode_nxt;
      push_res.sat_symbol_rate = sr_nxt;
      push_res.sat_fec = fec_nxt;
      push_res.terr_present = terp_nxt;
      push_res.terr_frequency = tf_nxt;
      push_res.terr_params = tp_nxt;
    end
    if (!take) push = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= PH_IDLE; sbl_r <= '0; tsl_r <= '0; edl_r <= '0;
      tag_r <= '0; dbl_r <= '0; dbi_r <= '0; crc_r <= 32'hFFFF_FFFF;
      hdr_r <= '0; err_r <= 1'b0;
      tsid_r <= '0; onid_r <= '0; satp_r <= 1'b0; terp_r <= 1'b0;
      freq_r <= '0; orb_r <= '0; mode_r <= '0; sr_r <= '0;
      fec_r <= '0; tf_r <= '0; tp_r <= '0;
    end else if (take) begin
      ph_r <= ph_nxt; sbl_r <= sbl_nxt; tsl_r <= tsl_nxt; edl_r <= edl_nxt;
      tag_r <= tag_nxt; dbl_r <= dbl_nxt; dbi_r <= dbi_nxt; crc_r <= crc_nxt;
      hdr_r <= hdr_nxt; err_r <= err_nxt;
      tsid_r <= tsid_nxt; onid_r <= onid_nxt; satp_r <= satp_nxt; terp_r <= terp_nxt;
      freq_r <= freq_nxt; orb_r <= orb_nxt; mode_r <= mode_nxt; sr_r <= sr_nxt;
      fec_r <= fec_nxt; tf_r <= tf_nxt; tp_r <= tp_nxt;
    end
  end
endmodule

@@ design/nsp_queue.sv @@
`timescale 1ns / 1ps
module nsp_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  nsp_pkg::res_t push_res,
  input  logic          pop,
  output logic          not_empty,
  output logic          has_room,
  output nsp_pkg::res_t head
);
  import nsp_pkg::*;

  res_t        mem [4];
  logic [1:0]  wp_r, wp_nxt, rp_r, rp_nxt;
  logic [2:0]  cnt_r, cnt_nxt;

  assign not_empty = (cnt_r != 3'd0);
  assign has_room  = (cnt_r != 3'd4);
  assign head      = mem[rp_r];

  always_comb begin
    wp_nxt  = push ? wp_r + 2'd1 : wp_r;
    rp_nxt  = pop ? rp_r + 2'd1 : rp_r;
    cnt_nxt = cnt_r + {2'b0, push} - {2'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (push) mem[wp_r] <= push_res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      wp_r <= wp_nxt; rp_r <= rp_nxt; cnt_r <= cnt_nxt;
    end
  end
endmodule

@@ design/nsp_back.sv @@
`timescale 1ns / 1ps
module nsp_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  input  nsp_pkg::res_t q_res,
  output logic          q_pop,
  output logic          out_valid,
  input  logic          out_ready,
  output nsp_pkg::res_t out_res
);
  import nsp_pkg::*;

  logic vld_r, vld_nxt;
  res_t res_r;

  assign q_pop     = q_valid && (!vld_r || out_ready);
  assign vld_nxt   = q_pop || (vld_r && !out_ready);
  assign out_valid = vld_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (q_pop) res_r <= q_res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= 1'b0;
    else vld_r <= vld_nxt;
  end
endmodule

@@ design/nit_section_parser.sv @@
`timescale 1ns / 1ps
// NIT section parser: one section byte per cycle in, one word of results out.
// Throughput: one byte every cycle while the result queue has room.
// Results pass from the front through the result queue to a registered output.
// Reset (rst_n low, synchronous): parser idles until a section start byte,
// CRC preset to all ones, result queue and output register emptied.
module nit_section_parser #(
  parameter int MAX_SECTION_BYTES = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_section_start,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [15:0] out_ident,
  output logic [15:0] out_original_net,
  output logic        out_sat_present,
  output logic [26:0] out_sat_frequency,
  output logic [13:0] out_sat_orbit,
  output logic [7:0]  out_sat_mode_bits,
  output logic [23:0] out_sat_symbol_rate,
  output logic [3:0]  out_sat_fec,
  output logic        out_terr_present,
  output logic [31:0] out_terr_frequency,
  output logic [21:0] out_terr_params
);
  import nsp_pkg::*;

  logic take, push, q_ne, q_room, q_pop;
  res_t push_res, q_head, o_res;

  // a byte yields at most one word, so one free slot is enough to accept
  assign in_ready = q_room;
  assign take     = in_valid && in_ready;

  // front: byte walker, CRC and BCD conversion
  nsp_front #(.MAX_SECTION_BYTES(MAX_SECTION_BYTES)) u_front (
    .clk, .rst_n, .take,
    .data_byte(in_data_byte), .section_start(in_section_start),
    .push, .push_res
  );

  // four-word queue decouples parsing from the consumer
  nsp_queue u_queue (
    .clk, .rst_n, .push, .push_res, .pop(q_pop),
    .not_empty(q_ne), .has_room(q_room), .head(q_head)
  );

  // back: registered output word
  nsp_back u_back (
    .clk, .rst_n, .q_valid(q_ne), .q_res(q_head), .q_pop,
    .out_valid, .out_ready, .out_res(o_res)
  );

  assign out_kind            = o_res.kind;
  assign out_ident           = o_res.ident;
  assign out_original_net    = o_res.original_net;
  assign out_sat_present     = o_res.sat_present;
  assign out_sat_frequency   = o_res.sat_frequency;
  assign out_sat_orbit       = o_res.sat_orbit;
  assign out_sat_mode_bits   = o_res.sat_mode_bits;
  assign out_sat_symbol_rate = o_res.sat_symbol_rate;
  assign out_sat_fec         = o_res.sat_fec;
  assign out_terr_present    = o_res.terr_present;
  assign out_terr_frequency  = o_res.terr_frequency;
  assign out_terr_params     = o_res.terr_params;
endmodule

@@ verif/nit_section_parser_tb.sv @@
`timescale 1ns / 1ps
module nit_section_parser_tb;
  import nsp_pkg::*;

  localparam int MAX_BYTES = 1024;
  localparam int CYCLE_LIMIT = 400000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_data_byte;
  logic        in_section_start;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  out_kind;
  logic [15:0] out_ident;
  logic [15:0] out_original_net;
  logic        out_sat_present;
  logic [26:0] out_sat_frequency;
  logic [13:0] out_sat_orbit;
  logic [7:0]  out_sat_mode_bits;
  logic [23:0] out_sat_symbol_rate;
  logic [3:0]  out_sat_fec;
  logic        out_terr_present;
  logic [31:0] out_terr_frequency;
  logic [21:0] out_terr_params;

  nit_section_parser #(.MAX_SECTION_BYTES(MAX_BYTES)) i_dut (.*);

  // 4 ns clock
  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Scoreboard state
  // ---------------------------------------------------------------------------
  res_t   result_q[$];      // results the parser still owes us
  int     words_taken;      // input words accepted so far
  int     results_seen;
  int     sections_sent;
  int     mismatches;
  int     cycles;
  bit     idle_on;          // sender inserts gaps
  bit     stall_on;         // receiver drops ready in bursts
  int     stall_left;
  logic [7:0] sec[$];       // section under construction

  // ---------------------------------------------------------------------------
  // Parser predictor: mirrors the section walk, one byte per call
  // ---------------------------------------------------------------------------
  phase_t      ph;
  int          sec_left, loop_left, edesc_left;
  logic [7:0]  dtag, dleft, bidx;
  logic [31:0] crc_acc;
  res_t        rec;           // transport stream entry being collected
  logic [15:0] net_id;
  logic [21:0] stat_params;   // version, current, section, last section
  bit          struct_err;

  function automatic logic [31:0] crc_next(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    r = c ^ {b, 24'h0};
    for (int i = 0; i < 8; i++) r = r[31] ? ((r << 1) ^ 32'h04C11DB7) : (r << 1);
    return r;
  endfunction

  // BCD accumulate with saturation; nibbles above 9 keep their weight
  function automatic longint sat_acc(input longint acc, input longint dig, input longint scale,
                                     input longint cap);
    longint v;
    v = acc * scale + dig;
    return (v > cap) ? cap : v;
  endfunction

  function automatic void parser_clear();
    ph = PH_IDLE;
    sec_left = 0; loop_left = 0; edesc_left = 0;
    dtag = '0; dleft = '0; bidx = '0;
    crc_acc = '1;
    rec = '0;
    net_id = '0; stat_params = '0; struct_err = 0;
  endfunction

  function automatic void flag_struct();
    struct_err = 1;
    ph = PH_SKIP;
  endfunction

  function automatic res_t section_status();
    res_t o;
    o = '0;
    if (crc_acc != 0) o.kind = KIND_CRC;
    else if (struct_err) o.kind = KIND_STRUCT;
    else o.kind = KIND_OK;
    o.ident = net_id;
    o.terr_params = stat_params;
    ph = PH_IDLE;
    return o;
  endfunction

  function automatic res_t entry_done();
    res_t o;
    o = rec;
    o.kind = KIND_TS;
    bidx = '0;
    ph = (loop_left != 0) ? PH_ENTRY : PH_CRC;
    return o;
  endfunction

  function automatic void sat_body(input logic [7:0] b, input logic [7:0] i);
    longint pair;
    pair = b[7:4] * 10 + b[3:0];
    if (i < 4) rec.sat_frequency = 27'(sat_acc(rec.sat_frequency, pair, 100, 99999999));
    else if (i < 6) rec.sat_orbit = 14'(sat_acc(rec.sat_orbit, pair, 100, 9999));
    else if (i == 6) rec.sat_mode_bits = b;
    else if (i < 10)
      rec.sat_symbol_rate = 24'(sat_acc(rec.sat_symbol_rate, pair, 100, 9999999));
    else if (i == 10) begin
      rec.sat_symbol_rate = 24'(sat_acc(rec.sat_symbol_rate, longint'(b[7:4]), 10, 9999999));
      rec.sat_fec = b[3:0];
    end
  endfunction

  function automatic void terr_body(input logic [7:0] b, input logic [7:0] i);
    if (i < 4) rec.terr_frequency = {rec.terr_frequency[23:0], b};
    else if (i == 4) rec.terr_params[21:16] = b[7:2];
    else if (i == 5) rec.terr_params[15:8] = b;
    else if (i == 6) rec.terr_params[7:0] = b;
  endfunction

  function automatic void parse_word(input logic [7:0] b, input logic start);
    int   v;
    bit   emit;
    res_t o;
    emit = 0;
    o = '0;
    if (start) begin
      // section start abandons whatever was in progress
      parser_clear();
      crc_acc = crc_next(crc_acc, b);
      ph = PH_LEN1;
      return;
    end
    if (ph == PH_IDLE) return;   // stray bytes between sections
    crc_acc = crc_next(crc_acc, b);
    if (ph == PH_LEN1) begin
      sec_left = int'({b[3:0], 8'h00});
      ph = PH_LEN2;
      return;
    end
    if (ph == PH_LEN2) begin
      v = sec_left | int'(b);
      if (v + 3 > MAX_BYTES) begin
        // oversize: bare structure error right away
        o.kind = KIND_STRUCT;
        result_q.push_back(o);
        ph = PH_IDLE;
        return;
      end
      sec_left = v;
      bidx = '0;
      ph = PH_HDR;
      if (v < 13) struct_err = 1;
      if (v == 0) result_q.push_back(section_status());
      return;
    end
    sec_left = (sec_left - 1) & 12'hFFF;
    case (ph)
      PH_HDR: begin
        case (bidx)
          0: net_id[15:8] = b;
          1: net_id[7:0] = b;
          2: stat_params[21:16] = {b[5:1], b[0]};
          3: stat_params[15:8] = b;
          4: stat_params[7:0] = b;
          5: loop_left = int'({b[3:0], 8'h00});
          default: begin
            v = loop_left | int'(b);
            if (struct_err || v + 6 > sec_left) flag_struct();
            else begin
              loop_left = v;
              ph = (v != 0) ? PH_NETDESC : PH_TSL1;
            end
          end
        endcase
        bidx++;
      end
      PH_NETDESC: begin
        loop_left = (loop_left - 1) & 12'hFFF;
        if (loop_left == 0) ph = PH_TSL1;
      end
      PH_TSL1: begin
        loop_left = int'({b[3:0], 8'h00});
        ph = PH_TSL2;
      end
      PH_TSL2: begin
        v = loop_left | int'(b);
        if (v == 0 || v + 4 != sec_left) flag_struct();
        else begin
          loop_left = v;
          bidx = '0;
          ph = PH_ENTRY;
        end
      end
      PH_ENTRY: begin
        if (bidx == 0 && loop_left < 6) flag_struct();
        else begin
          if (bidx == 0) rec = '0;
          loop_left = (loop_left - 1) & 12'hFFF;
          case (bidx)
            0: rec.ident[15:8] = b;
            1: rec.ident[7:0] = b;
            2: rec.original_net[15:8] = b;
            3: rec.original_net[7:0] = b;
            4: edesc_left = int'({b[3:0], 8'h00});
            default: begin
              v = edesc_left | int'(b);
              if (v > loop_left) flag_struct();
              else begin
                edesc_left = v;
                if (v == 0) begin
                  o = entry_done();
                  emit = 1;
                end else ph = PH_DTAG;
              end
            end
          endcase
          if (ph == PH_ENTRY && !emit) bidx++;
        end
      end
      PH_DTAG: begin
        if (edesc_left < 2) flag_struct();
        else begin
          loop_left = (loop_left - 1) & 12'hFFF;
          edesc_left = (edesc_left - 1) & 12'hFFF;
          dtag = b;
          ph = PH_DLEN;
        end
      end
      PH_DLEN: begin
        loop_left = (loop_left - 1) & 12'hFFF;
        edesc_left = (edesc_left - 1) & 12'hFFF;
        if (b > edesc_left || (dtag == TAG_SAT && b < 11) || (dtag == TAG_TERR && b < 7))
          flag_struct();
        else begin
          // a repeated descriptor replaces the earlier one
          if (dtag == TAG_SAT) begin
            rec.sat_frequency = '0; rec.sat_orbit = '0; rec.sat_mode_bits = '0;
            rec.sat_symbol_rate = '0; rec.sat_fec = '0;
            rec.sat_present = 1'b1;
          end else if (dtag == TAG_TERR) begin
            rec.terr_frequency = '0; rec.terr_params = '0;
            rec.terr_present = 1'b1;
          end
          dleft = b;
          bidx = '0;
          if (b != 0) ph = PH_DBODY;
          else if (edesc_left == 0) begin
            o = entry_done();
            emit = 1;
          end else ph = PH_DTAG;
        end
      end
      PH_DBODY: begin
        loop_left = (loop_left - 1) & 12'hFFF;
        edesc_left = (edesc_left - 1) & 12'hFFF;
        if (dtag == TAG_SAT) sat_body(b, bidx);
        else if (dtag == TAG_TERR) terr_body(b, bidx);
        if (bidx < 255) bidx++;
        dleft--;
        if (dleft == 0) begin
          if (edesc_left == 0) begin
            o = entry_done();
            emit = 1;
          end else ph = PH_DTAG;
        end
      end
      default: ;
    endcase
    // last byte of the section: status wins over any record
    if (sec_left == 0) begin
      o = section_status();
      emit = 1;
    end
    if (emit) result_q.push_back(o);
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: predict on every accepted input word, check every result word
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input longint got, input longint want);
    mismatches++;
    $display("MISMATCH result %0d %s: got 0x%0h want 0x%0h", results_seen, what, got, want);
  endtask

  always @(posedge clk) begin
    res_t w;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results pending", cycles, result_q.size());
      $display("Regression FAIL");
      $finish;
    end else if (rst_n) begin
      if (in_valid && in_ready) begin
        parse_word(in_data_byte, in_section_start);
        words_taken++;
      end
      if (out_valid && out_ready) begin
        if (result_q.size() == 0) begin
          report_mismatch("unexpected word, kind", out_kind, 0);
        end else begin
          w = result_q.pop_front();
          if (out_kind != w.kind) report_mismatch("kind", out_kind, w.kind);
          if (out_ident != w.ident) report_mismatch("ident", out_ident, w.ident);
          if (out_original_net != w.original_net)
            report_mismatch("original_net", out_original_net, w.original_net);
          if (out_sat_present != w.sat_present)
            report_mismatch("sat_present", out_sat_present, w.sat_present);
          if (out_sat_frequency != w.sat_frequency)
            report_mismatch("sat_frequency", out_sat_frequency, w.sat_frequency);
          if (out_sat_orbit != w.sat_orbit)
            report_mismatch("sat_orbit", out_sat_orbit, w.sat_orbit);
          if (out_sat_mode_bits != w.sat_mode_bits)
            report_mismatch("sat_mode_bits", out_sat_mode_bits, w.sat_mode_bits);
          if (out_sat_symbol_rate != w.sat_symbol_rate)
            report_mismatch("sat_symbol_rate", out_sat_symbol_rate, w.sat_symbol_rate);
          if (out_sat_fec != w.sat_fec) report_mismatch("sat_fec", out_sat_fec, w.sat_fec);
          if (out_terr_present != w.terr_present)
            report_mismatch("terr_present", out_terr_present, w.terr_present);
          if (out_terr_frequency != w.terr_frequency)
            report_mismatch("terr_frequency", out_terr_frequency, w.terr_frequency);
          if (out_terr_params != w.terr_params)
            report_mismatch("terr_params", out_terr_params, w.terr_params);
        end
        results_seen++;
      end
    end
  end

  // Receiver: ready drops in bursts while stalling is enabled
  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else if (stall_left != 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (stall_on && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(0, 17);
      out_ready <= 1'b0;
    end else out_ready <= 1'b1;
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  // one input word; returns at the edge where it was taken
  task automatic send_word(input logic [7:0] b, input logic start);
    int target;
    if (idle_on && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    target = words_taken + 1;
    in_valid <= 1'b1;
    in_data_byte <= b;
    in_section_start <= start;
    wait (words_taken == target);
  endtask

  task automatic send_section(input int count);
    for (int i = 0; i < count && i < sec.size(); i++) send_word(sec[i], i == 0);
    sections_sent++;
  endtask

  task automatic send_noise(input int count);
    repeat (count) send_word(8'($urandom_range(0, 255)), 1'b0);
  endtask

  function automatic logic [7:0] bcd_byte(input bit junk);
    if (junk) return 8'($urandom_range(0, 255));
    return {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
  endfunction

  task automatic seal_crc();
    logic [31:0] c;
    c = '1;
    foreach (sec[i]) c = crc_next(c, sec[i]);
    for (int k = 3; k >= 0; k--) sec.push_back(c[8*k +: 8]);
  endtask

  // descriptor kinds: 0 satellite, 1 terrestrial, 2 other tag,
  // 3 satellite too short, 4 terrestrial too short, 5 satellite all 0xFF digits
  task automatic add_desc(input int kind);
    int len;
    bit junk;
    logic [7:0] tg;
    junk = ($urandom_range(0, 3) == 0);
    case (kind)
      0, 5: begin
        len = 11 + $urandom_range(0, 2);
        sec.push_back(TAG_SAT);
        sec.push_back(8'(len));
        for (int i = 0; i < len; i++)
          if (kind == 5) sec.push_back(8'hFF);
          else if (i == 6 || i == 10 || i > 10) sec.push_back(8'($urandom_range(0, 255)));
          else sec.push_back(bcd_byte(junk));
      end
      1: begin
        len = 7 + $urandom_range(0, 4);
        sec.push_back(TAG_TERR);
        sec.push_back(8'(len));
        repeat (len) sec.push_back(8'($urandom_range(0, 255)));
      end
      3, 4: begin
        len = (kind == 3) ? $urandom_range(0, 10) : $urandom_range(0, 6);
        sec.push_back((kind == 3) ? TAG_SAT : TAG_TERR);
        sec.push_back(8'(len));
        repeat (len) sec.push_back(8'($urandom_range(0, 255)));
      end
      default: begin
        do tg = 8'($urandom_range(0, 255)); while (tg == TAG_SAT || tg == TAG_TERR);
        len = $urandom_range(0, 4);
        sec.push_back(tg);
        sec.push_back(8'(len));
        repeat (len) sec.push_back(8'($urandom_range(0, 255)));
      end
    endcase
  endtask

  // section with consistent lengths and CRC; first_kind >= 0 forces that descriptor into entry 0
  task automatic build_section(input int n_ent, input int first_kind);
    int nd, tsi, dli, from, n, sl;
    sec = {};
    sec.push_back(8'(8'h40 + $urandom_range(0, 1)));
    sec.push_back(8'h00);
    sec.push_back(8'h00);
    repeat (5) sec.push_back(8'($urandom_range(0, 255)));    // network id, version, numbers
    nd = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 6) : 0;
    sec.push_back({4'($urandom_range(0, 15)), 4'h0});
    sec.push_back(8'(nd));
    repeat (nd) sec.push_back(8'($urandom_range(0, 255)));
    tsi = sec.size();
    sec.push_back(8'h00);
    sec.push_back(8'h00);
    for (int e = 0; e < n_ent; e++) begin
      repeat (4) sec.push_back(8'($urandom_range(0, 255)));
      dli = sec.size();
      sec.push_back(8'h00);
      sec.push_back(8'h00);
      from = sec.size();
      if (e == 0 && first_kind >= 0) add_desc(first_kind);
      repeat ($urandom_range(0, 3)) add_desc($urandom_range(0, 4) % 3);
      n = sec.size() - from;
      sec[dli] = {4'($urandom_range(0, 15)), 4'(n >> 8)};
      sec[dli + 1] = n[7:0];
    end
    n = sec.size() - tsi - 2;
    sec[tsi] = {4'($urandom_range(0, 15)), 4'(n >> 8)};
    sec[tsi + 1] = n[7:0];
    sl = sec.size() - 3 + 4;
    sec[1] = {4'($urandom_range(0, 15)), 4'(sl >> 8)};
    sec[2] = sl[7:0];
    seal_crc();
  endtask

  // overwrite one byte; optionally re-seal so the CRC check does not catch the fault
  task automatic poke_section(input bit reseal);
    int idx;
    idx = $urandom_range(1, sec.size() - 5);
    sec[idx] = 8'($urandom_range(0, 255));
    if (reseal) begin
      repeat (4) void'(sec.pop_back());
      seal_crc();
    end
  endtask

  // stop sending and wait until every predicted word has been checked
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (result_q.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_clean_sections();
    build_section(1, 0);            // satellite delivery
    send_section(sec.size());
    build_section(2, 1);            // terrestrial delivery
    send_section(sec.size());
    build_section(1, 2);            // unknown descriptor first
    send_section(sec.size());
    build_section(3, 5);            // nibbles above 9: saturated sums
    send_section(sec.size());
    build_section(1, -1);
    for (int i = 3; i < 7; i++) sec[i] = 8'hFF;   // extreme header fields
    repeat (4) void'(sec.pop_back());
    seal_crc();
    send_section(sec.size());
    drain();
  endtask

  task automatic test_repeated_descriptors();
    build_section(1, 0);
    // rebuild as a fresh two-entry section, satellite descriptor first
    build_section(2, 0);
    send_section(sec.size());
    build_section(1, 1);
    send_section(sec.size());
    drain();
  endtask

  task automatic test_bad_structure();
    build_section(1, 3);            // satellite descriptor too short
    send_section(sec.size());
    build_section(1, 4);            // terrestrial descriptor too short
    send_section(sec.size());
    build_section(0, -1);           // empty transport loop
    send_section(sec.size());
    build_section(2, 0);
    poke_section(1'b0);             // corrupt byte, crc left stale
    send_section(sec.size());
    build_section(2, 1);
    poke_section(1'b1);             // corrupt byte, crc resealed
    send_section(sec.size());
    drain();
  endtask

  task automatic test_length_extremes();
    sec = {8'h40, 8'hFF, 8'hFF};    // oversize length
    send_section(3);
    sec = {8'h40, 8'hF0, 8'h00};    // zero length ends at once
    send_section(3);
    sec = {8'h40, 8'h00, 8'h05, 8'h12, 8'h34, 8'hC1, 8'h00, 8'h00};  // below minimum
    send_section(sec.size());
    drain();
  endtask

  task automatic test_restart_and_idle_bytes();
    send_noise(6);                  // ignored while idle
    build_section(2, 0);
    send_section(sec.size() / 2);   // abandoned by the next start
    build_section(1, 1);
    send_section(sec.size());
    send_noise(3);
    drain();
  endtask

  task automatic test_random(input int word_goal, input bit gaps);
    int start_words;
    int mode;
    start_words = words_taken;
    while (words_taken - start_words < word_goal) begin
      idle_on = gaps && ($urandom_range(0, 3) != 0);
      stall_on = gaps && ($urandom_range(0, 3) != 0);
      build_section($urandom_range(1, 3), ($urandom_range(0, 2) == 0) ? $urandom_range(0, 5) : -1);
      mode = $urandom_range(0, 9);
      if (mode == 0) poke_section(1'b0);
      else if (mode == 1) poke_section(1'b1);
      if (mode == 2) send_section($urandom_range(1, sec.size() - 1));
      else send_section(sec.size());
      if ($urandom_range(0, 5) == 0) send_noise($urandom_range(1, 3));
    end
    idle_on = 0;
    stall_on = 0;
    drain();
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data_byte = '0;
    in_section_start = 1'b0;
    out_ready = 1'b0;
    idle_on = 1'b1;
    stall_on = 1'b1;
    stall_left = 0;
    words_taken = 0;
    results_seen = 0;
    sections_sent = 0;
    mismatches = 0;
    cycles = 0;
    parser_clear();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_clean_sections();
    test_repeated_descriptors();
    test_bad_structure();
    test_length_extremes();
    test_restart_and_idle_bytes();
    test_random(40, 1'b1);
    test_random(40, 1'b0);          // closing stretch at full rate

    drain();
    repeat (10) @(posedge clk);
    $display("Sent %0d sections in %0d words; %0d result words checked.",
             sections_sent, words_taken, results_seen);
    $display("Covered records, status kinds, restarts, oversize and broken layouts.");
    if (mismatches == 0 && result_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/nsp_pkg.sv
design/nsp_front.sv
design/nsp_queue.sv
design/nsp_back.sv
design/nit_section_parser.sv
verif/nit_section_parser_tb.sv
